// ===== hw/rtl/plbf_pkg.sv =====
// ----------------------------------------------------------------------------
// plbf_pkg - shared types and helpers for the parallel led frame store
// Sizes of the frame store, input and result transfer types, and the
// color merge that spreads a scaled color byte over one interleaved word.
// ----------------------------------------------------------------------------
package plbf_pkg;

	// frame geometry
	localparam int LEDS_PER_LANE  = 9;
	localparam int LANE_COUNT     = 4;
	localparam int COLORS_PER_LED = 3;
	localparam int WORD_COUNT     = COLORS_PER_LED * LEDS_PER_LANE;
	localparam int ADDR_W         = $clog2(WORD_COUNT);
	localparam int CNT_W          = $clog2(WORD_COUNT + 1);
	localparam int STEP_W         = $clog2(COLORS_PER_LED + 1);
	localparam int LED_CMP_W      = 5;

	// color limits and scaling
	localparam logic [63:0] CLEAR_PATTERN = 64'hEEEE_EEEE_EEEE_EEEE;
	localparam logic [31:0] COLOR_LIMIT   = 32'h00FF_FFFF;
	localparam int IN_MAX      = 255;
	localparam int OUT_MAX     = 15;
	localparam int SCALE_DIV   = IN_MAX / OUT_MAX;
	// floor(x / 17) == (x * 241) >> 12 for every 8-bit x
	localparam int SCALE_MUL   = 241;
	localparam int SCALE_SHIFT = 12;

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// status codes
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  lane;
		logic [3:0]  led;
		logic [31:0] color;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] word;
		logic        last;
	} out_item_t;

	// store access requested by the sequencer
	typedef struct packed {
		logic        rd_en;
		addr_t       rd_addr;
		logic        wr_en;
		addr_t       wr_addr;
		logic [31:0] wr_data;
	} store_req_t;

	// color byte scaled to 0..15
	function automatic logic [3:0] scale_level(input logic [7:0] color_byte);
		logic [15:0] prod;
		prod = {8'b0, color_byte} * 16'(SCALE_MUL);
		return prod[SCALE_SHIFT +: 4];
	endfunction

	// clear the lane bit of every nibble, then place level bit i at 4*i+lane
	function automatic logic [31:0] merge_channel(input logic [31:0] word,
		input logic [1:0] lane, input logic [7:0] color_byte);
		logic [63:0] shifted;
		logic [31:0] keep;
		logic [3:0]  level;
		logic [31:0] spread;
		shifted = CLEAR_PATTERN << lane;
		keep    = shifted[63:32];
		level   = scale_level(color_byte);
		spread  = '0;
		for (int i = 0; i < 4; i++) begin
			spread[4*i] = level[i];
		end
		return (word & keep) | (spread << lane);
	endfunction

endpackage

// ===== hw/rtl/parallel_led_bitplane_framebuffer.sv =====
// ----------------------------------------------------------------------------
// parallel_led_bitplane_framebuffer - bit-interleaved frame store, 4 strips
// Writes merge one led color into its three interleaved words; a readout
// streams every frame word in order and flags the last one.
// ----------------------------------------------------------------------------
//  channel   ports                    transfer when
//  input     start, item, busy        start high and busy low at clk rise
//  result    strobe, result           strobe high at clk rise
//
//  valid write: busy while three reads overlap three write-backs on the
//  store's read and write ports, result as busy falls
//  rejected write: busy stays low, result in the next cycle
//  readout: busy while every frame word streams, one word per cycle, set by the
//  store's single read port
//  reset clears the store at once through per-word valid flags
//  the receiver cannot stall: each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module parallel_led_bitplane_framebuffer
	import plbf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	output logic      strobe,
	output out_item_t result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WRITE,
		S_READ
	} state_t;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COLORS_PER_LED);
	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WORD_COUNT);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              strobe_q;
	out_item_t         result_q;

	logic [1:0]        lane_q;
	logic [23:0]       color_q;
	addr_t             base_q;

	store_req_t        req;
	logic [31:0]       rd_data;
	logic [7:0]        byte_sel;
	logic              reject;

	plbf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// range check of a write
	assign reject = (item.color > COLOR_LIMIT)
		|| ({1'b0, item.lane} >= 4'(LANE_COUNT))
		|| ({1'b0, item.led} >= LED_CMP_W'(LEDS_PER_LANE));

	// color byte for the word being written back
	always_comb begin
		unique case (step_q)
			STEP_W'(1): byte_sel = color_q[23:16];
			STEP_W'(2): byte_sel = color_q[15:8];
			default:    byte_sel = color_q[7:0];
		endcase
	end

	// store requests: each write-back goes in the cycle after the read of its word
	always_comb begin
		req = '0;
		unique case (state_q)
			S_WRITE: begin
				req.rd_en   = (step_q != STEP_LAST);
				req.rd_addr = ADDR_W'(base_q + ADDR_W'(step_q));
				req.wr_en   = (step_q != '0);
				req.wr_addr = ADDR_W'(base_q + ADDR_W'(step_q) - ADDR_W'(1));
				req.wr_data = merge_channel(rd_data, lane_q, byte_sel);
			end
			S_READ: begin
				req.rd_en   = (cnt_q < CNT_LAST);
				req.rd_addr = cnt_q[ADDR_W-1:0];
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// captured write fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			lane_q  <= item.lane[1:0];
			color_q <= item.color[23:0];
			base_q  <= ADDR_W'(int'(item.led) * COLORS_PER_LED);
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
					if (start) begin
						if (item.action == ACT_READ) begin
							state_q <= S_READ;
						end else if (reject) begin
							strobe_q <= 1'b1;
							result_q <= '{status: ST_REJECT, word: 32'h0, last: 1'b1};
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q  <= S_IDLE;
						strobe_q <= 1'b1;
						result_q <= '{status: ST_OK, word: 32'h0, last: 1'b1};
					end
				end
				S_READ: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q != '0) begin
						strobe_q <= 1'b1;
						result_q <= '{status: ST_OK, word: rd_data, last: (cnt_q == CNT_LAST)};
					end
					if (cnt_q == CNT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// an accepted item either keeps the block busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || strobe))
		else $error("accepted item neither started work nor gave a result");

	// a write-back never targets the word being read in the same cycle
	a_no_same_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
		else $error("store read and write hit the same word");

	// rejected writes carry no word and close the item
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status == ST_REJECT) |-> (result.word == '0 && result.last))
		else $error("rejected write result malformed");

	// readout words come back to back until the last one
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=> strobe)
		else $error("gap in readout stream");

	// no result while a write is still modifying the store
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && step_q != '0) |-> !strobe)
		else $error("result during write-back");

endmodule

// ===== hw/rtl/plbf_store.sv =====
// ----------------------------------------------------------------------------
// plbf_store - frame word memory
// One write port and one registered read port; per-word valid flags make
// never-written words read as zero right after reset.
// ----------------------------------------------------------------------------
module plbf_store
	import plbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  store_req_t  req,
	output logic [31:0] rd_data
);

	logic [31:0]           mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] valid_q;
	logic [31:0]           rd_word_q;
	logic                  rd_valid_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_addr];
		end
	end

	// valid flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// unwritten words read as zero
	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

// ===== bench/parallel_led_bitplane_framebuffer_test.sv =====
// ----------------------------------------------------------------------------
// parallel_led_bitplane_framebuffer_test - frame store write and readout check
// Drives led color writes, rejected writes and full frame readouts with
// random gaps, keeps a shadow copy of the interleaved frame, and compares
// every result transfer field by field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parallel_led_bitplane_framebuffer_test;
	import plbf_pkg::*;

	localparam int GAP_MAX      = 12;
	localparam int RANDOM_ITEMS = 480;
	localparam int BURST_BLOCK  = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int REPORT_MAX   = 10;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	in_item_t  item;
	logic      busy;
	logic      strobe;
	out_item_t result;

	// shadow frame and results still owed by the block
	logic [31:0] shadow_frame [WORD_COUNT];
	out_item_t   pending_results [$];
	out_item_t   oldest_result;
	int          fail_count = 0;
	bit          back_to_back = 1'b0;

	parallel_led_bitplane_framebuffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// count a failure, report only the first few
	task automatic record_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// append one expected result at the tail of the queue
	task automatic queue_expected(input out_item_t res);
		pending_results.insert(pending_results.size(), res);
	endtask

	// update the shadow frame and queue the results one command causes
	task automatic predict_command(input in_item_t cmd);
		out_item_t   res;
		int          base;
		logic [7:0]  channel_byte;
		logic [3:0]  intensity;
		logic [31:0] merged;
		if (cmd.action == ACT_READ) begin
			for (int k = 0; k < WORD_COUNT; k++) begin
				res.status = ST_OK;
				res.word   = shadow_frame[k];
				res.last   = (k == WORD_COUNT - 1);
				queue_expected(res);
			end
		end else if (cmd.color > COLOR_LIMIT || cmd.lane >= LANE_COUNT ||
				cmd.led >= LEDS_PER_LANE) begin
			res.status = ST_REJECT;
			res.word   = '0;
			res.last   = 1'b1;
			queue_expected(res);
		end else begin
			base = cmd.led * COLORS_PER_LED;
			// red, green, blue bytes go to consecutive words
			for (int c = 0; c < COLORS_PER_LED; c++) begin
				channel_byte = cmd.color[8 * (COLORS_PER_LED - 1 - c) +: 8];
				intensity    = 4'(channel_byte / 8'd17);
				merged       = shadow_frame[base + c] & ~(32'h1111_1111 << cmd.lane);
				for (int i = 0; i < 4; i++) begin
					merged[4 * i + cmd.lane] = intensity[i];
				end
				shadow_frame[base + c] = merged;
			end
			res.status = ST_OK;
			res.word   = '0;
			res.last   = 1'b1;
			queue_expected(res);
		end
	endtask

	// one command transfer after a random gap, or none in back-to-back blocks
	task automatic send_command(input in_item_t cmd);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item  <= cmd;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_command(cmd);
	endtask

	function automatic in_item_t make_write(input logic [2:0] lane, input logic [3:0] led,
		input logic [31:0] color);
		in_item_t cmd;
		cmd.action = ACT_WRITE;
		cmd.lane   = lane;
		cmd.led    = led;
		cmd.color  = color;
		return cmd;
	endfunction

	// readout with junk in the ignored fields
	function automatic in_item_t make_readout();
		in_item_t cmd;
		cmd.action = ACT_READ;
		cmd.lane   = 3'($urandom);
		cmd.led    = 4'($urandom);
		cmd.color  = $urandom;
		return cmd;
	endfunction

	// color byte biased to the ends of the range and the first scale step
	function automatic logic [7:0] pick_channel_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'(16 + $urandom_range(0, 1));
			default: return 8'($urandom);
		endcase
	endfunction

	// store must read back all zero after reset
	task automatic test_reset_readout();
		send_command(make_readout());
	endtask

	// corner lanes, leds and colors, including zero bytes that only clear
	task automatic test_write_extremes();
		send_command(make_write(3'd0, 4'd0, 32'h00FF_FFFF));
		send_command(make_write(3'd3, 4'd8, 32'h00FF_FFFF));
		send_command(make_write(3'd1, 4'd4, 32'h0011_2233));
		send_command(make_write(3'd2, 4'd4, 32'h0010_EF22));
		send_command(make_write(3'd0, 4'd0, 32'h0000_FF00));
		send_command(make_write(3'd3, 4'd8, 32'h0000_0000));
		send_command(make_write(3'd2, 4'd8, 32'h0080_1011));
		send_command(make_readout());
	endtask

	// out of range lane, led or color leaves the frame untouched
	task automatic test_rejected_writes();
		send_command(make_write(3'd4, 4'd0, 32'h00FF_FFFF));
		send_command(make_write(3'd7, 4'd8, 32'h0012_3456));
		send_command(make_write(3'd1, 4'd9, 32'h00FF_FFFF));
		send_command(make_write(3'd3, 4'd15, 32'h0000_0001));
		send_command(make_write(3'd0, 4'd0, 32'h0100_0000));
		send_command(make_write(3'd2, 4'd3, 32'hFFFF_FFFF));
		send_command(make_write(3'd7, 4'd15, 32'h8000_0000));
		send_command(make_readout());
	endtask

	// mostly valid writes with randomly placed readouts, some malformed commands
	task automatic test_random_traffic();
		int       kind;
		in_item_t cmd;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			back_to_back = ((n / BURST_BLOCK) % 3 == 2);
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				cmd = make_readout();
			end else if (kind < 85) begin
				cmd = make_write(3'($urandom_range(0, LANE_COUNT - 1)),
					4'($urandom_range(0, LEDS_PER_LANE - 1)),
					{8'h00, pick_channel_byte(), pick_channel_byte(), pick_channel_byte()});
			end else begin
				cmd = make_write(3'($urandom), 4'($urandom),
					($urandom_range(0, 1) == 0) ? 32'($urandom) : {8'h00, 24'($urandom)});
			end
			send_command(cmd);
		end
		back_to_back = 1'b0;
	endtask

	// compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				record_failure($sformatf("unexpected result: status %0d word %h last %0d",
					result.status, result.word, result.last));
			end else begin
				oldest_result = pending_results.pop_front();
				if (result.status !== oldest_result.status ||
						result.word !== oldest_result.word ||
						result.last !== oldest_result.last) begin
					record_failure($sformatf(
						"mismatch: expected status %0d word %h last %0d, got status %0d word %h last %0d",
						oldest_result.status, oldest_result.word, oldest_result.last,
						result.status, result.word, result.last));
				end
			end
		end
	end

	// sequence of tests
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		for (int k = 0; k < WORD_COUNT; k++) begin
			shadow_frame[k] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_readout();
		test_write_extremes();
		test_rejected_writes();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		for (int d = 0; d < DRAIN_LIMIT && pending_results.size() != 0; d++) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			record_failure($sformatf("%0d expected results never arrived",
				pending_results.size()));
		end

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== parallel_led_bitplane_framebuffer.f =====
hw/rtl/plbf_pkg.sv
hw/rtl/plbf_store.sv
hw/rtl/parallel_led_bitplane_framebuffer.sv
bench/parallel_led_bitplane_framebuffer_test.sv
